FILE: rtl/kfsa_pkg.sv
// kfsa_pkg: shared widths, reset constants and controller state type
// for the k-th free slot allocator. No dependencies.
package kfsa_pkg;

  localparam int RANK_W = 11;
  localparam int SLOT_W = 10;
  localparam int CFG_W  = 11;
  localparam int CNT_W  = 11;

  localparam logic [CFG_W-1:0] CFG_RESET = 11'd1024;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CLEAR,
    ST_ROOT,
    ST_DESCEND,
    ST_FINISH
  } kfsa_state_e;

endpackage

FILE: rtl/kfsa_count_ram.sv
// kfsa_count_ram: count tree storage, one write port and one read port,
// read data registered. Depends on kfsa_pkg.
module kfsa_count_ram import kfsa_pkg::*; #(
  parameter int ADDR_W = 11
) (
  input  logic              clk_i,
  input  logic              wr_en_i,
  input  logic [ADDR_W-1:0] wr_addr_i,
  input  logic [CNT_W-1:0]  wr_data_i,
  input  logic              rd_en_i,
  input  logic [ADDR_W-1:0] rd_addr_i,
  output logic [CNT_W-1:0]  rd_data_o
);

  localparam int DEPTH = 1 << ADDR_W;

  logic [CNT_W-1:0] mem_q [DEPTH];
  logic [CNT_W-1:0] rd_data_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_data_q <= mem_q[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

FILE: rtl/kth_free_slot_allocator_unit.sv
// kth_free_slot_allocator_unit: top level, controller and output register.
// Depends on kfsa_pkg and kfsa_count_ram.
//
// Usage
// - Input channel (in_valid_i / in_stall_o): one transfer is one request.
//   restart_i = 1 refills the free map: slots below min(slots_in_use, SLOTS)
//   become free, all others taken. Otherwise rank_i = k selects the k-th
//   free slot counting from slot zero, returns it and marks it taken.
// - Output channel (out_valid_o / out_stall_i): exactly one result per
//   request. found_o = 0 with slot_o = 0 on restart, on rank zero and on a
//   rank above the free count; on a miss the map is untouched.
// - Config channel (cfg_valid_i / cfg_ready_o): writes slots_in_use, always
//   ready. The value is used at the next restart only.
// Operation
// - A select makes one read of the root count, then one count RAM read
//   per tree level while the counts along the path are decremented and
//   written back.
// - A restart rewrites every tree node, one per cycle.
// - After reset the same fill pass runs with slots_in_use = 1024; the input
//   is stalled until it ends.
// - A request is taken while an earlier result still waits in the output
//   register; a stalled receiver holds the next result in ST_FINISH, which stalls the input.
module kth_free_slot_allocator_unit import kfsa_pkg::*; #(
  parameter int SLOTS = 1024
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  logic [RANK_W-1:0] rank_i,
  input  logic              restart_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output logic [SLOT_W-1:0] slot_o,
  output logic              found_o,
  input  logic              cfg_valid_i,
  output logic              cfg_ready_o,
  input  logic [CFG_W-1:0]  cfg_slots_in_use_i
);

  localparam int SW = $clog2(SLOTS);         // slot index bits
  localparam int NW = SW + 1;                // tree node index bits
  localparam int LW = (SW + 1 > CFG_W) ? SW + 1 : CFG_W;
  localparam logic [LW-1:0] LEAF_BASE = LW'(1) << SW;
  localparam logic [LW-1:0] SLOTS_L   = LW'(SLOTS);
  localparam logic [LW-1:0] LIM_RESET =
      (LW'(CFG_RESET) > SLOTS_L) ? SLOTS_L : LW'(CFG_RESET);

  kfsa_state_e state_q, state_d;

  logic [CFG_W-1:0]  slots_in_use_q;
  logic [NW-1:0]     node_q, node_d;
  logic [RANK_W-1:0] k_q, k_d;
  logic [CNT_W-1:0]  cur_q, cur_d;
  logic [LW-1:0]     lim_q, lim_d;
  logic [LW-1:0]     size_q, size_d;
  logic [LW-1:0]     base_q, base_d;
  logic              emit_q, emit_d;
  logic [SLOT_W-1:0] res_slot_q, res_slot_d;
  logic              res_found_q, res_found_d;
  logic              out_valid_q, out_valid_d;
  logic [SLOT_W-1:0] slot_q, slot_d;
  logic              found_q, found_d;

  logic              accept;
  logic              out_free;
  logic              root_miss;
  logic              go_left;
  logic [NW-1:0]     child;
  logic              child_leaf;
  logic [CNT_W-1:0]  ccount;
  logic              sweep_last;
  logic [LW-1:0]     cfg_ext;
  logic [LW-1:0]     lim_sat;
  logic [LW-1:0]     init_diff;
  logic [CNT_W-1:0]  init_cnt;

  logic              fin;
  logic [SLOT_W-1:0] fin_slot;
  logic              fin_found;

  logic              wr_en;
  logic [NW-1:0]     wr_addr;
  logic [CNT_W-1:0]  wr_data;
  logic              rd_en;
  logic [NW-1:0]     rd_addr;
  logic [CNT_W-1:0]  rd_data;

  kfsa_count_ram #(
    .ADDR_W (NW)
  ) u_count_ram (
    .clk_i     (clk_i),
    .wr_en_i   (wr_en),
    .wr_addr_i (wr_addr),
    .wr_data_i (wr_data),
    .rd_en_i   (rd_en),
    .rd_addr_i (rd_addr),
    .rd_data_o (rd_data)
  );

  // handshakes
  assign cfg_ready_o = 1'b1;
  assign in_stall_o  = (state_q != ST_IDLE);
  assign accept      = in_valid_i && !in_stall_o;
  assign out_free    = !out_valid_q || !out_stall_i;

  // descent step: rd_data is the root count in ST_ROOT, else the count of the left child of node_q
  assign root_miss  = (k_q == '0) || (k_q > rd_data);
  assign go_left    = (rd_data >= k_q);
  assign child      = {node_q[NW-2:0], !go_left};
  assign child_leaf = child[NW-1];
  assign ccount     = go_left ? rd_data : CNT_W'(cur_q - rd_data);

  // fill pass: node count = clamp(lim - base, 0, size), level by level
  assign sweep_last = &node_q;
  assign cfg_ext    = LW'(slots_in_use_q);
  assign lim_sat    = (cfg_ext > SLOTS_L) ? SLOTS_L : cfg_ext;
  assign init_diff  = lim_q - base_q;
  assign init_cnt   = (lim_q <= base_q) ? '0 :
                      (init_diff > size_q) ? CNT_W'(size_q) : CNT_W'(init_diff);

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          state_d = restart_i ? ST_CLEAR : ST_ROOT;
        end
      end
      ST_CLEAR: begin
        if (sweep_last) begin
          state_d = (emit_q && !out_free) ? ST_FINISH : ST_IDLE;
        end
      end
      ST_ROOT: begin
        if (root_miss) begin
          state_d = out_free ? ST_IDLE : ST_FINISH;
        end else begin
          state_d = ST_DESCEND;
        end
      end
      ST_DESCEND: begin
        if (child_leaf) begin
          state_d = out_free ? ST_IDLE : ST_FINISH;
        end
      end
      ST_FINISH: begin
        if (out_free) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // datapath and RAM control
  always_comb begin
    node_d    = node_q;
    k_d       = k_q;
    cur_d     = cur_q;
    lim_d     = lim_q;
    size_d    = size_q;
    base_d    = base_q;
    emit_d    = emit_q;
    fin       = 1'b0;
    fin_slot  = '0;
    fin_found = 1'b0;
    wr_en     = 1'b0;
    wr_addr   = node_q;
    wr_data   = init_cnt;
    rd_en     = 1'b0;
    rd_addr   = {node_q[NW-2:0], 1'b0};
    case (state_q)
      ST_IDLE: begin
        rd_addr = NW'(1);
        if (accept) begin
          k_d    = rank_i;
          node_d = NW'(1);
          if (restart_i) begin
            lim_d  = lim_sat;
            size_d = LEAF_BASE;
            base_d = '0;
            emit_d = 1'b1;
          end else begin
            rd_en = 1'b1;
          end
        end
      end
      ST_CLEAR: begin
        wr_en  = 1'b1;
        node_d = NW'(node_q + 1'b1);
        if ((node_q & NW'(node_q + 1'b1)) == '0) begin
          size_d = size_q >> 1;
          base_d = '0;
        end else begin
          base_d = base_q + size_q;
        end
        if (sweep_last) begin
          fin    = emit_q;
          emit_d = 1'b0;
        end
      end
      ST_ROOT: begin
        if (root_miss) begin
          fin = 1'b1;
        end else begin
          wr_en   = 1'b1;
          wr_data = CNT_W'(rd_data - 1'b1);
          cur_d   = rd_data;
          rd_en   = 1'b1;
        end
      end
      ST_DESCEND: begin
        wr_en   = 1'b1;
        wr_addr = child;
        wr_data = CNT_W'(ccount - 1'b1);
        node_d  = child;
        cur_d   = ccount;
        if (!go_left) begin
          k_d = RANK_W'(k_q - rd_data);
        end
        if (child_leaf) begin
          fin       = 1'b1;
          fin_found = 1'b1;
          fin_slot  = SLOT_W'(child[SW-1:0]);
        end else begin
          rd_en   = 1'b1;
          rd_addr = {child[NW-2:0], 1'b0};
        end
      end
      ST_FINISH: begin
      end
      default: begin
      end
    endcase
  end

  // result holding and output register
  always_comb begin
    res_slot_d  = fin ? fin_slot : res_slot_q;
    res_found_d = fin ? fin_found : res_found_q;
    out_valid_d = out_valid_q && out_stall_i;
    slot_d      = slot_q;
    found_d     = found_q;
    if (out_free && fin) begin
      out_valid_d = 1'b1;
      slot_d      = fin_slot;
      found_d     = fin_found;
    end else if (out_free && (state_q == ST_FINISH)) begin
      out_valid_d = 1'b1;
      slot_d      = res_slot_q;
      found_d     = res_found_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q        <= ST_CLEAR;
      slots_in_use_q <= CFG_RESET;
      node_q         <= NW'(1);
      lim_q          <= LIM_RESET;
      size_q         <= LEAF_BASE;
      base_q         <= '0;
      emit_q         <= 1'b0;
      out_valid_q    <= 1'b0;
    end else begin
      state_q     <= state_d;
      node_q      <= node_d;
      lim_q       <= lim_d;
      size_q      <= size_d;
      base_q      <= base_d;
      emit_q      <= emit_d;
      out_valid_q <= out_valid_d;
      if (cfg_valid_i && cfg_ready_o) begin
        slots_in_use_q <= cfg_slots_in_use_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    k_q         <= k_d;
    cur_q       <= cur_d;
    res_slot_q  <= res_slot_d;
    res_found_q <= res_found_d;
    slot_q      <= slot_d;
    found_q     <= found_d;
  end

  assign out_valid_o = out_valid_q;
  assign slot_o      = slot_q;
  assign found_o     = found_q;

`ifndef SYNTH
  // rank stays within the subtree count all the way down
  a_rank_in_subtree: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_DESCEND) |-> (k_q != '0) && (k_q <= cur_q) && (ccount != '0))
    else $error("rank outside subtree count during descent");

  // a selected leaf is a real slot, never padding
  a_leaf_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_DESCEND) && child_leaf |-> (32'(child[SW-1:0]) < SLOTS))
    else $error("descent reached a padding leaf");

  // the fill pass ends only after the last node is written
  a_fill_complete: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $past(state_q == ST_CLEAR) && (state_q != ST_CLEAR) |-> $past(sweep_last))
    else $error("fill pass left early");

  // a restart transfer starts the fill pass
  a_restart_fills: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && restart_i |=> (state_q == ST_CLEAR) && emit_q)
    else $error("restart did not start fill pass");
`endif

endmodule

FILE: bench/kth_free_slot_allocator_unit_tb.sv
// Self-checking bench for kth_free_slot_allocator_unit: directed table, then three random
// phases with varied idling, results checked against typed rows or a free-map predictor.
// Depends on kfsa_pkg and the allocator RTL.
`timescale 1ns / 100ps

module kth_free_slot_allocator_unit_tb;
  import kfsa_pkg::*;

  localparam int NSLOTS       = 1024;
  localparam int CLK_PERIOD   = 10;
  localparam int PHASE_ITEMS  = 125;
  localparam int HOLD_CYCLES  = 400;   // long receiver hold-off, fills the block
  localparam int REFILL_WAIT  = 2100;  // quiet stretch before a register write
  localparam int QUIET_LIMIT  = 20000; // cycles without any transfer
  localparam int DIR_ROWS     = 26;

  typedef struct packed {
    logic [SLOT_W-1:0] slot;
    logic              found;
  } slot_result_t;

  typedef enum logic {ROW_ITEM, ROW_CFG} row_kind_e;

  // One row of the directed table. value is the rank for a request or the
  // register value for a config write. typed rows carry a hand-written result.
  typedef struct packed {
    row_kind_e         kind;
    logic              restart;
    logic [RANK_W-1:0] value;
    logic              typed;
    logic [SLOT_W-1:0] exp_slot;
    logic              exp_found;
  } dir_row_t;

  logic              clk_i = 1'b0;
  logic              rst_ni = 1'b0;
  logic              in_valid_i = 1'b0;
  logic              in_stall_o;
  logic [RANK_W-1:0] rank_i = '0;
  logic              restart_i = 1'b0;
  logic              out_valid_o;
  logic              out_stall_i = 1'b0;
  logic [SLOT_W-1:0] slot_o;
  logic              found_o;
  logic              cfg_valid_i = 1'b0;
  logic              cfg_ready_o;
  logic [CFG_W-1:0]  cfg_slots_in_use_i = '0;

  always #(CLK_PERIOD / 2) clk_i = ~clk_i;

  kth_free_slot_allocator_unit #(
    .SLOTS(NSLOTS)
  ) uut (
    .clk_i,
    .rst_ni,
    .in_valid_i,
    .in_stall_o,
    .rank_i,
    .restart_i,
    .out_valid_o,
    .out_stall_i,
    .slot_o,
    .found_o,
    .cfg_valid_i,
    .cfg_ready_o,
    .cfg_slots_in_use_i
  );

  // ---------------------------------------------------------------------------
  // Predictor: flat free map plus a running free count. A linear scan finds the
  // k-th free slot, which is what the count-tree descent must agree with.
  // ---------------------------------------------------------------------------
  logic [NSLOTS-1:0] free_map;
  int unsigned       free_total;
  logic [CFG_W-1:0]  slots_cfg;   // register copy, only used at refill

  slot_result_t pending_results[$];

  int unsigned errs = 0;
  int unsigned requests = 0;
  int unsigned restarts = 0;
  int unsigned results_checked = 0;
  int unsigned slots_claimed = 0;
  int unsigned cfg_writes = 0;
  int unsigned quiet_cycles = 0;

  // idle rates in percent; rcv_pct is read by the receiver process, so it is
  // only ever changed with a nonblocking assignment
  int unsigned snd_pct = 0;
  int unsigned rcv_pct = 0;
  logic        hold_tog = 1'b0;
  logic        hold_seen = 1'b0;
  int unsigned hold_left = 0;

  function automatic void refill_free_map();
    int unsigned lim;
    lim = (slots_cfg > NSLOTS) ? NSLOTS : slots_cfg;  // register saturates at the map size
    for (int i = 0; i < NSLOTS; i++) free_map[i] = (i < lim);
    free_total = lim;
  endfunction

  function automatic slot_result_t claim_kth_free(input logic restart,
                                                  input logic [RANK_W-1:0] rank);
    slot_result_t res;
    int unsigned  seen;
    res  = '0;
    seen = 0;
    if (restart) begin
      refill_free_map();
    end else if (rank != 0 && rank <= free_total) begin
      // rank zero or past the free count: not found, map untouched
      for (int i = 0; i < NSLOTS && !res.found; i++) begin
        if (free_map[i]) begin
          seen++;
          if (seen == rank) begin
            res.slot    = SLOT_W'(i);
            res.found   = 1'b1;
            free_map[i] = 1'b0;
            free_total--;
          end
        end
      end
    end
    return res;
  endfunction

  // ---------------------------------------------------------------------------
  // Receiver: random stall, or a long hold-off requested by a toggle of hold_tog.
  // ---------------------------------------------------------------------------
  always @(posedge clk_i) begin
    if (hold_tog != hold_seen) begin
      hold_seen   <= hold_tog;
      hold_left   <= HOLD_CYCLES;
      out_stall_i <= 1'b1;
    end else if (hold_left != 0) begin
      hold_left   <= hold_left - 1;
      out_stall_i <= 1'b1;
    end else begin
      out_stall_i <= ($urandom_range(99) < rcv_pct);
    end
  end

  // ---------------------------------------------------------------------------
  // Monitor on the falling edge: handshake signals are settled there, and a
  // transfer seen here completes at the next rising edge. Result checking and
  // the quiet-cycle count for the watchdog both live here.
  // ---------------------------------------------------------------------------
  always @(negedge clk_i) begin
    slot_result_t exp_res;
    if (!rst_ni) begin
      quiet_cycles <= 0;
    end else begin
      if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i) ||
          (cfg_valid_i && cfg_ready_o))
        quiet_cycles <= 0;
      else
        quiet_cycles <= quiet_cycles + 1;

      if (out_valid_o && !out_stall_i) begin
        if (pending_results.size() == 0) begin
          errs++;
          $display("%0t: result transfer with nothing expected: slot %0d found %0b",
                   $time, slot_o, found_o);
        end else begin
          exp_res = pending_results.pop_front();
          results_checked++;
          if (found_o === 1'b1) slots_claimed++;
          if (slot_o !== exp_res.slot) begin
            errs++;
            $display("%0t: slot mismatch, expected %0d got %0d",
                     $time, exp_res.slot, slot_o);
          end
          if (found_o !== exp_res.found) begin
            errs++;
            $display("%0t: found mismatch, expected %0b got %0b",
                     $time, exp_res.found, found_o);
          end
        end
      end
    end
  end

  // watchdog: too long without any transfer means the block hung
  initial begin : watchdog
    while (quiet_cycles < QUIET_LIMIT) @(negedge clk_i);
    $display("%0t: no transfer for %0d cycles, %0d results outstanding",
             $time, QUIET_LIMIT, pending_results.size());
    $display("simulation failed");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Driver tasks. Every task is entered and left at a rising edge. valid is
  // lowered only when a gap follows, so it never gets two updates in one step.
  // ---------------------------------------------------------------------------
  task automatic send_request(input logic restart, input logic [RANK_W-1:0] rank,
                              input logic typed, input slot_result_t typed_res);
    int unsigned  gap;
    slot_result_t res;
    gap = 0;
    while ($urandom_range(99) < snd_pct) gap++;
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    restart_i  <= restart;
    rank_i     <= rank;
    do @(negedge clk_i); while (in_stall_o);
    @(posedge clk_i);
    // transfer happened at this edge
    res = claim_kth_free(restart, rank);
    pending_results.push_back(typed ? typed_res : res);
    requests++;
    if (restart) restarts++;
  endtask

  task automatic go_quiet();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
  endtask

  // sender pauses until every result is back
  task automatic wait_all_results();
    go_quiet();
    while (pending_results.size() != 0) @(posedge clk_i);
  endtask

  // register write only with the block idle: every result is back, and a
  // refill pass ends before its result, so nothing is in flight any more
  task automatic write_slots_in_use(input logic [CFG_W-1:0] value);
    wait_all_results();
    repeat (REFILL_WAIT) @(posedge clk_i);
    cfg_valid_i        <= 1'b1;
    cfg_slots_in_use_i <= value;
    do @(negedge clk_i); while (!cfg_ready_o);
    @(posedge clk_i);
    cfg_valid_i <= 1'b0;
    slots_cfg = value;  // takes effect at the next restart only
    cfg_writes++;
  endtask

  // ---------------------------------------------------------------------------
  // Directed table. Starts from the reset map: 1024 slots free.
  // ---------------------------------------------------------------------------
  function automatic dir_row_t directed_row(input int idx);
    dir_row_t r;
    case (idx)
      // rank zero and ranks past the free count
      0:  r = '{ROW_ITEM, 1'b0, 11'd0,    1'b1, 10'd0,    1'b0};
      1:  r = '{ROW_ITEM, 1'b0, 11'd2047, 1'b1, 10'd0,    1'b0};
      2:  r = '{ROW_ITEM, 1'b0, 11'd1025, 1'b1, 10'd0,    1'b0};
      // last free slot, then the same rank once the count has dropped
      3:  r = '{ROW_ITEM, 1'b0, 11'd1024, 1'b1, 10'd1023, 1'b1};
      4:  r = '{ROW_ITEM, 1'b0, 11'd1024, 1'b1, 10'd0,    1'b0};
      5:  r = '{ROW_ITEM, 1'b0, 11'd1,    1'b1, 10'd0,    1'b1};
      6:  r = '{ROW_ITEM, 1'b0, 11'd1,    1'b0, 10'd0,    1'b0};
      7:  r = '{ROW_ITEM, 1'b0, 11'd512,  1'b0, 10'd0,    1'b0};
      8:  r = '{ROW_ITEM, 1'b0, 11'd1021, 1'b0, 10'd0,    1'b0};
      9:  r = '{ROW_ITEM, 1'b0, 11'd1020, 1'b0, 10'd0,    1'b0};
      // restart ignores the rank field
      10: r = '{ROW_ITEM, 1'b1, 11'd1366, 1'b1, 10'd0,    1'b0};
      11: r = '{ROW_ITEM, 1'b0, 11'd1024, 1'b1, 10'd1023, 1'b1};
      // one slot: the write must not touch the map until the restart
      12: r = '{ROW_CFG,  1'b0, 11'd1,    1'b0, 10'd0,    1'b0};
      13: r = '{ROW_ITEM, 1'b0, 11'd5,    1'b0, 10'd0,    1'b0};
      14: r = '{ROW_ITEM, 1'b1, 11'd0,    1'b1, 10'd0,    1'b0};
      15: r = '{ROW_ITEM, 1'b0, 11'd2,    1'b1, 10'd0,    1'b0};
      16: r = '{ROW_ITEM, 1'b0, 11'd1,    1'b1, 10'd0,    1'b1};
      17: r = '{ROW_ITEM, 1'b0, 11'd1,    1'b1, 10'd0,    1'b0};
      // zero slots: every slot stays taken
      18: r = '{ROW_CFG,  1'b0, 11'd0,    1'b0, 10'd0,    1'b0};
      19: r = '{ROW_ITEM, 1'b1, 11'd2047, 1'b1, 10'd0,    1'b0};
      20: r = '{ROW_ITEM, 1'b0, 11'd1,    1'b1, 10'd0,    1'b0};
      // register past the map size saturates
      21: r = '{ROW_CFG,  1'b0, 11'd2047, 1'b0, 10'd0,    1'b0};
      22: r = '{ROW_ITEM, 1'b1, 11'd0,    1'b1, 10'd0,    1'b0};
      23: r = '{ROW_ITEM, 1'b0, 11'd1024, 1'b1, 10'd1023, 1'b1};
      24: r = '{ROW_ITEM, 1'b0, 11'd1023, 1'b1, 10'd1022, 1'b1};
      default: r = '{ROW_ITEM, 1'b0, 11'd682, 1'b0, 10'd0, 1'b0};
    endcase
    return r;
  endfunction

  // random request: mostly ranks inside the free count, so the map really
  // drains; the rest are boundary ranks, rank zero, raw 11-bit noise and restarts
  task automatic send_random_request();
    int unsigned       pick;
    logic [RANK_W-1:0] rank;
    pick = $urandom_range(99);
    if (pick < 3) begin
      send_request(1'b1, RANK_W'($urandom_range(2047)), 1'b0, '0);
    end else begin
      if (pick < 83 && free_total != 0)
        rank = ($urandom_range(9) == 0) ? RANK_W'(free_total)
                                        : RANK_W'($urandom_range(free_total, 1));
      else if (pick < 88)
        rank = RANK_W'(free_total + 1);
      else if (pick < 91)
        rank = '0;
      else
        rank = RANK_W'($urandom_range(2047));
      send_request(1'b0, rank, 1'b0, '0);
    end
  endtask

  initial begin : stimulus
    dir_row_t     row;
    slot_result_t typed_res;

    slots_cfg = CFG_RESET;
    refill_free_map();

    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    // the block runs its fill pass now; the first request waits on in_stall_o

    for (int i = 0; i < DIR_ROWS; i++) begin
      row = directed_row(i);
      if (row.kind == ROW_CFG) begin
        write_slots_in_use(row.value);
      end else begin
        typed_res = '{slot: row.exp_slot, found: row.exp_found};
        send_request(row.restart, row.value, row.typed, typed_res);
      end
    end

    // three phases: slow receiver, slow sender, then no random idling
    for (int phase = 0; phase < 3; phase++) begin
      case (phase)
        0: begin
          snd_pct = 15;
          rcv_pct <= 83;
          write_slots_in_use(CFG_W'($urandom_range(64, 2)));  // small map, drains fully
        end
        1: begin
          snd_pct = 83;
          rcv_pct <= 15;
          write_slots_in_use(CFG_W'($urandom_range(2047)));
        end
        default: begin
          snd_pct = 0;
          rcv_pct <= 0;
          write_slots_in_use(CFG_W'(NSLOTS));
        end
      endcase
      send_request(1'b1, '0, 1'b0, '0);
      // back-to-back requests against a held-off receiver fill the block
      if (phase == 2) hold_tog <= ~hold_tog;
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        if (n == PHASE_ITEMS / 2) wait_all_results();
        send_random_request();
      end
    end

    wait_all_results();
    repeat (40) @(posedge clk_i);

    $display("covered %0d requests (%0d restarts), %0d results checked, %0d slots claimed",
             requests, restarts, results_checked, slots_claimed);
    $display("%0d register writes, idle mixes: slow receiver, slow sender, none", cfg_writes);
    if (errs == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
